/* sv/cih_pkg.sv */
// cih_pkg: shared constants, codes and transaction types for the
// cumulative interval histogram. No dependencies.
package cih_pkg;

  localparam int NUM_BOUNDS  = 7;
  localparam int NUM_BUCKETS = NUM_BOUNDS + 1;
  localparam int CTR_W       = 64;
  localparam int BOUND_W     = 63;
  localparam int IVAL_W      = 64;
  localparam int SEL_W       = 3;
  localparam int CFG_IDX_W   = 3;

  // register index of the bucket count register
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_IN_USE = 3'd7;

  localparam logic [BOUND_W-1:0] BOUND_RESET [NUM_BOUNDS] = '{
    63'd1000, 63'd10000, 63'd100000, 63'd1000000,
    63'd10000000, 63'd100000000, 63'd1000000000
  };
  localparam logic [SEL_W-1:0] BOUNDS_IN_USE_RESET = 3'd7;

  typedef enum logic {
    OP_OBSERVE = 1'b0,
    OP_READ    = 1'b1
  } opcode_t;

  // classified transaction handed from front to back
  typedef struct packed {
    logic [NUM_BUCKETS-1:0] hit;       // buckets to increment
    logic                   positive;  // sample accepted
    logic [IVAL_W-1:0]      interval;
    logic [SEL_W-1:0]       sel;
    logic                   sel_ok;    // selection within overflow bucket
    logic                   ignored;
  } item_t;

  // result transaction
  typedef struct packed {
    logic [CTR_W-1:0] bucket_count;
    logic [CTR_W-1:0] total_sum;
    logic [CTR_W-1:0] total_count;
    logic             sample_ignored;
  } result_t;

endpackage

/* sv/cih_front.sv */
// cih_front: bound registers, config decode and classification of input
// transactions against the bucket bounds. Depends on cih_pkg.
module cih_front import cih_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 opcode,
  input  logic signed [63:0]   duration_us,
  input  logic [SEL_W-1:0]     bucket_select,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BOUND_W-1:0]   cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output item_t                q_item
);

  logic [BOUND_W-1:0] bounds [NUM_BOUNDS];
  logic [SEL_W-1:0]   bounds_in_use;
  logic [SEL_W-1:0]   n_eff;
  logic               positive;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BOUNDS; i++) bounds[i] <= BOUND_RESET[i];
      bounds_in_use <= BOUNDS_IN_USE_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_BOUNDS_IN_USE) begin
        bounds_in_use <= cfg_data[SEL_W-1:0];
      end else begin
        bounds[cfg_index] <= cfg_data;
      end
    end
  end

  // zero buckets in use acts as one
  assign n_eff = (bounds_in_use == '0) ? SEL_W'(1) : bounds_in_use;

  assign positive = (opcode == OP_OBSERVE) && !duration_us[IVAL_W-1] &&
                    (duration_us != '0);

  // parallel bound compares, overflow bucket hit by every positive sample
  always_comb begin
    q_item = '0;
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      q_item.hit[i] = positive && (SEL_W'(i) < n_eff) &&
                      (bounds[i] >= duration_us[BOUND_W-1:0]);
    end
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      if (SEL_W'(b) == n_eff) q_item.hit[b] = positive;
    end
    q_item.positive = positive;
    q_item.interval = duration_us;
    q_item.sel      = bucket_select;
    q_item.sel_ok   = (bucket_select <= n_eff);
    q_item.ignored  = (opcode == OP_OBSERVE) && !positive;
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

endmodule

/* sv/cih_queue.sv */
// cih_queue: two-entry queue of classified transactions between front
// and back. Depends on cih_pkg.
module cih_queue import cih_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd,
  output item_t rd_item,
  output logic  empty
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_item = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_item;
  end

endmodule

/* sv/cih_back.sv */
// cih_back: bucket counters, running sum and sample count, plus the
// two-entry result queue. Depends on cih_pkg.
module cih_back import cih_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  item_t            q_item,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [CTR_W-1:0] bucket_count,
  output logic [CTR_W-1:0] total_sum,
  output logic [CTR_W-1:0] total_count,
  output logic             sample_ignored
);

  logic [CTR_W-1:0] counts      [NUM_BUCKETS];
  logic [CTR_W-1:0] counts_next [NUM_BUCKETS];
  logic [CTR_W-1:0] sum;
  logic [CTR_W-1:0] sum_next;
  logic [CTR_W-1:0] samples;
  logic [CTR_W-1:0] samples_next;
  logic             take;
  result_t          res;

  result_t    rmem [2];
  logic       r_wr_ptr;
  logic       r_rd_ptr;
  logic [1:0] r_count;
  logic       r_full;
  logic       r_pop;

  assign r_full = (r_count == 2'd2);
  assign take   = !q_empty && !r_full;
  assign q_pop  = take;

  // counter updates for the transaction at the queue head
  always_comb begin
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      counts_next[b] = counts[b] + CTR_W'(take && q_item.hit[b]);
    end
    sum_next     = (take && q_item.positive) ? sum + q_item.interval : sum;
    samples_next = samples + CTR_W'(take && q_item.positive);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NUM_BUCKETS; b++) counts[b] <= '0;
      sum     <= '0;
      samples <= '0;
    end else begin
      for (int b = 0; b < NUM_BUCKETS; b++) counts[b] <= counts_next[b];
      sum     <= sum_next;
      samples <= samples_next;
    end
  end

  // result after this transaction is applied
  always_comb begin
    res.bucket_count   = q_item.sel_ok ? counts_next[q_item.sel] : '0;
    res.total_sum      = sum_next;
    res.total_count    = samples_next;
    res.sample_ignored = q_item.ignored;
  end

  // result queue
  assign empty = (r_count == 2'd0);
  assign r_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_wr_ptr <= 1'b0;
      r_rd_ptr <= 1'b0;
      r_count  <= 2'd0;
    end else begin
      if (take)  r_wr_ptr <= ~r_wr_ptr;
      if (r_pop) r_rd_ptr <= ~r_rd_ptr;
      r_count <= r_count + {1'b0, take} - {1'b0, r_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (take) rmem[r_wr_ptr] <= res;
  end

  assign bucket_count   = rmem[r_rd_ptr].bucket_count;
  assign total_sum      = rmem[r_rd_ptr].total_sum;
  assign total_count    = rmem[r_rd_ptr].total_count;
  assign sample_ignored = rmem[r_rd_ptr].sample_ignored;

endmodule

/* sv/cumulative_interval_histogram_top.sv */
// cumulative_interval_histogram_top: top level of the interval histogram.
// Depends on cih_pkg, cih_front, cih_queue and cih_back.
//
// Usage:
// - Input channel: push/full. A transaction carries opcode (observe or
//   read), duration_us and bucket_select. It is taken when push is high
//   and full is low.
// - Result channel: empty/pop. While empty is low the oldest result is on
//   bucket_count, total_sum, total_count and sample_ignored; it is taken
//   when pop is high.
// - Config: cfg_write with cfg_index 0..6 writes a bucket bound, index 7
//   writes the number of finite buckets in use. Write only while idle.
// - Latency: an input is first written into the input queue; the back end
//   then applies it and writes its result into the result queue.
// - Throughput: one transaction per cycle unless the result queue is full;
//   the back end updates all bucket counters with parallel incrementers.
// - A two-entry queue sits between front and back, and another in front
//   of the result ports; when pop is held low both fill and full rises
//   after four transactions wait.
// - Reset clears all counters, the sum, the sample count and both queues,
//   and restores the default bounds with seven buckets in use.
module cumulative_interval_histogram_top import cih_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 opcode,
  input  logic signed [63:0]   duration_us,
  input  logic [SEL_W-1:0]     bucket_select,
  output logic                 empty,
  input  logic                 pop,
  output logic [CTR_W-1:0]     bucket_count,
  output logic [CTR_W-1:0]     total_sum,
  output logic [CTR_W-1:0]     total_count,
  output logic                 sample_ignored,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BOUND_W-1:0]   cfg_data
);

  logic  q_full;
  logic  q_push;
  item_t q_wr_item;
  logic  q_pop;
  item_t q_rd_item;
  logic  q_empty;

  // classify incoming transactions
  cih_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .opcode        (opcode),
    .duration_us   (duration_us),
    .bucket_select (bucket_select),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_wr_item)
  );

  // decoupling queue
  cih_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .rd      (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  // counters and results
  cih_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_item         (q_rd_item),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .bucket_count   (bucket_count),
    .total_sum      (total_sum),
    .total_count    (total_count),
    .sample_ignored (sample_ignored)
  );

endmodule
